FILE: design/msadpcm_pkg.sv
// msadpcm_pkg: shared types, constants and tables of the ms adpcm block decoder
// no dependencies; imported by every module and interface of the block

package msadpcm_pkg;

  localparam int MaxBlockBytes = 4096;

  // configuration port
  localparam int CfgW    = 13;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgStereo     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockBytes = 1'b1;

  // datapath widths
  localparam int SampleW = 16;
  localparam int CoefW   = 12;
  localparam int ProdW   = SampleW + CoefW;
  localparam int AccW    = ProdW + 1;
  localparam int CmpW    = 17;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_PRED,
    DP_FIELD,
    DP_MUL_C1,
    DP_MUL_C2,
    DP_MUL_STEP,
    DP_MUL_ADAPT,
    DP_WRITE,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       capture;
    logic       ch;
    logic       first;
    logic [1:0] field;
    logic       hi_half;
    logic       code_lo;
    logic       emit_newer;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic signed [CoefW-1:0] coef_one_f(input logic [2:0] idx);
    logic signed [CoefW-1:0] c;
    case (idx)
      3'd0:    c = 12'sd256;
      3'd1:    c = 12'sd512;
      3'd2:    c = 12'sd0;
      3'd3:    c = 12'sd192;
      3'd4:    c = 12'sd240;
      3'd5:    c = 12'sd460;
      3'd6:    c = 12'sd392;
      default: c = 12'sd256;
    endcase
    return c;
  endfunction

  function automatic logic signed [CoefW-1:0] coef_two_f(input logic [2:0] idx);
    logic signed [CoefW-1:0] c;
    case (idx)
      3'd0:    c = 12'sd0;
      3'd1:    c = -12'sd256;
      3'd2:    c = 12'sd0;
      3'd3:    c = 12'sd64;
      3'd4:    c = 12'sd0;
      3'd5:    c = -12'sd208;
      3'd6:    c = -12'sd232;
      default: c = 12'sd0;
    endcase
    return c;
  endfunction

  function automatic logic [9:0] adapt_f(input logic [3:0] code);
    logic [9:0] a;
    case (code)
      4'd0, 4'd1, 4'd2, 4'd3: a = 10'd230;
      4'd4:    a = 10'd307;
      4'd5:    a = 10'd409;
      4'd6:    a = 10'd512;
      4'd7:    a = 10'd614;
      4'd8:    a = 10'd768;
      4'd9:    a = 10'd614;
      4'd10:   a = 10'd512;
      4'd11:   a = 10'd409;
      4'd12:   a = 10'd307;
      default: a = 10'd230;
    endcase
    return a;
  endfunction

endpackage

FILE: design/msadpcm_if.sv
// msadpcm_in_if / msadpcm_out_if: valid-ready channels of the decoder
// depends on msadpcm_pkg

interface msadpcm_in_if import msadpcm_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, data_byte, block_end, input ready);
  modport sink   (input valid, data_byte, block_end, output ready);
endinterface

interface msadpcm_out_if import msadpcm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_value;
  logic                      sample_channel;
  logic                      last_of_item;
  logic                      bad_predictor;

  modport source (output valid, sample_value, sample_channel, last_of_item, bad_predictor,
                  input ready);
  modport sink   (input valid, sample_value, sample_channel, last_of_item, bad_predictor,
                  output ready);
endinterface

FILE: design/msadpcm_dp.sv
// msadpcm_dp: channel state, shared multiplier, accumulator and output register
// depends on msadpcm_pkg; driven by msadpcm_ctrl commands

module msadpcm_dp import msadpcm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  output dp_status_t                status_o,
  input  logic [7:0]                data_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] sample_value_o,
  output logic                      sample_channel_o,
  output logic                      last_of_item_o,
  output logic                      bad_predictor_o
);

  localparam logic signed [AccW-1:0]    AccMin = AccW'(-32768);
  localparam logic signed [AccW-1:0]    AccMax = AccW'(32767);
  localparam logic signed [ProdW-9:0]   StepMin = (ProdW-8)'(16);
  localparam logic signed [ProdW-9:0]   StepMax = (ProdW-8)'(32767);

  logic signed [CoefW-1:0]   coef1_q [2];
  logic signed [CoefW-1:0]   coef2_q [2];
  logic signed [SampleW-1:0] step_q  [2];
  logic signed [SampleW-1:0] newer_q [2];
  logic signed [SampleW-1:0] older_q [2];
  logic [7:0]                hold_q;
  logic                      err_q;
  logic [7:0]                byte_q;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [AccW-1:0]    acc_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_sample_q;
  logic                      out_ch_q, out_last_q, out_bad_q;

  logic [3:0]                nib;
  logic signed [SampleW-1:0] mul_a;
  logic signed [CoefW-1:0]   mul_b;
  logic signed [AccW-9:0]    acc_div;
  logic signed [ProdW-9:0]   prod_div;
  logic signed [SampleW-1:0] sample_new, step_new, emit_val;
  logic                      pred_bad;
  logic [2:0]                pred_idx;
  logic [SampleW-1:0]        hdr_word;
  logic                      out_load;

  assign nib      = cmd_i.code_lo ? byte_q[3:0] : byte_q[7:4];
  assign pred_bad = data_byte_i > 8'd6;
  assign pred_idx = pred_bad ? 3'd0 : data_byte_i[2:0];
  assign hdr_word = {data_byte_i, hold_q};

  always_comb begin
    case (cmd_i.op)
      DP_MUL_C1: begin
        mul_a = newer_q[cmd_i.ch];
        mul_b = coef1_q[cmd_i.ch];
      end
      DP_MUL_C2: begin
        mul_a = older_q[cmd_i.ch];
        mul_b = coef2_q[cmd_i.ch];
      end
      DP_MUL_STEP: begin
        mul_a = step_q[cmd_i.ch];
        mul_b = CoefW'($signed(nib));
      end
      DP_MUL_ADAPT: begin
        mul_a = step_q[cmd_i.ch];
        mul_b = $signed({2'b00, adapt_f(nib)});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  // division by 256 rounding toward zero
  assign acc_div  = $signed(acc_q[AccW-1:8])
                  + (AccW-8)'(acc_q[AccW-1] && (acc_q[7:0] != 8'd0));
  assign prod_div = $signed(prod_q[ProdW-1:8])
                  + (ProdW-8)'(prod_q[ProdW-1] && (prod_q[7:0] != 8'd0));

  always_comb begin
    if (acc_q < AccMin) begin
      sample_new = SampleW'(AccMin);
    end else if (acc_q > AccMax) begin
      sample_new = SampleW'(AccMax);
    end else begin
      sample_new = acc_q[SampleW-1:0];
    end
    if (prod_div < StepMin) begin
      step_new = SampleW'(StepMin);
    end else if (prod_div > StepMax) begin
      step_new = SampleW'(StepMax);
    end else begin
      step_new = prod_div[SampleW-1:0];
    end
  end

  assign emit_val = cmd_i.emit_newer ? newer_q[cmd_i.ch] : older_q[cmd_i.ch];
  assign out_load = (cmd_i.op == DP_WRITE) || (cmd_i.op == DP_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        coef1_q[i] <= '0;
        coef2_q[i] <= '0;
        step_q[i]  <= SampleW'(16);
        newer_q[i] <= '0;
        older_q[i] <= '0;
      end
      hold_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_PRED: begin
          coef1_q[cmd_i.ch] <= coef_one_f(pred_idx);
          coef2_q[cmd_i.ch] <= coef_two_f(pred_idx);
          err_q             <= cmd_i.first ? pred_bad : (err_q | pred_bad);
        end
        DP_FIELD: begin
          if (!cmd_i.hi_half) begin
            hold_q <= data_byte_i;
          end else begin
            case (cmd_i.field)
              2'd0:    step_q[cmd_i.ch]  <= $signed(hdr_word);
              2'd1:    newer_q[cmd_i.ch] <= $signed(hdr_word);
              2'd2:    older_q[cmd_i.ch] <= $signed(hdr_word);
              default: ;
            endcase
          end
        end
        DP_WRITE: begin
          step_q[cmd_i.ch]  <= step_new;
          older_q[cmd_i.ch] <= newer_q[cmd_i.ch];
          newer_q[cmd_i.ch] <= sample_new;
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // arithmetic and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= data_byte_i;
    end
    // adapted step product held while the write waits for the output
    if (cmd_i.op != DP_IDLE) begin
      prod_q <= prod_d;
    end
    case (cmd_i.op)
      DP_MUL_C2:    acc_q <= AccW'(prod_q);
      DP_MUL_STEP:  acc_q <= acc_q + AccW'(prod_q);
      DP_MUL_ADAPT: acc_q <= AccW'(acc_div) + AccW'(prod_q);
      default: ;
    endcase
    if (out_load) begin
      out_sample_q <= (cmd_i.op == DP_WRITE) ? sample_new : emit_val;
      out_ch_q     <= cmd_i.ch;
      out_last_q   <= cmd_i.last;
      out_bad_q    <= err_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_value_o    = out_sample_q;
  assign sample_channel_o  = out_ch_q;
  assign last_of_item_o    = out_last_q;
  assign bad_predictor_o   = out_bad_q;

endmodule

FILE: design/msadpcm_ctrl.sv
// msadpcm_ctrl: configuration registers, block position and decode sequencer
// depends on msadpcm_pkg; issues commands to msadpcm_dp

module msadpcm_ctrl import msadpcm_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = MaxBlockBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_block_end_i,
  output logic               in_ready_o,
  output dp_cmd_t            cmd_o,
  input  dp_status_t         status_i
);

  localparam int PosW = $clog2(MAX_BLOCK_BYTES);
  localparam logic [CmpW-1:0] MaxLim = CmpW'(MAX_BLOCK_BYTES);
  localparam logic [CmpW-1:0] MinLim = CmpW'(16);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL1  = 7'b0000010,
    S_MUL2  = 7'b0000100,
    S_MUL3  = 7'b0001000,
    S_MUL4  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            code_q, code_d;
  logic [1:0]      emit_q, emit_d;
  logic            stereo_q;
  logic [CfgW-1:0] bbytes_q;

  logic [CmpW-1:0] chans, pos_ext, pos_inc, bb_ext, limit;
  logic            is_pred, is_field, last_hdr, accept, emit_last;
  logic [3:0]      q;

  assign chans    = stereo_q ? CmpW'(2) : CmpW'(1);
  assign pos_ext  = CmpW'(pos_q);
  assign pos_inc  = pos_ext + CmpW'(1);
  assign is_pred  = pos_ext < chans;
  assign is_field = pos_ext < CmpW'(7) * chans;
  assign last_hdr = pos_ext == CmpW'(7) * chans - CmpW'(1);
  assign q        = pos_q[3:0] - (stereo_q ? 4'd2 : 4'd1);
  assign bb_ext   = CmpW'(bbytes_q);
  assign limit    = (bb_ext < MinLim) ? MinLim : ((bb_ext > MaxLim) ? MaxLim : bb_ext);
  assign emit_last = emit_q == (stereo_q ? 2'd3 : 2'd1);

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    code_d  = code_q;
    emit_d  = emit_q;
    cmd_o   = '0;
    cmd_o.op = DP_IDLE;
    cmd_o.ch = stereo_q & code_q;
    cmd_o.code_lo = code_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d = (in_block_end_i || pos_inc >= limit) ? '0 : pos_inc[PosW-1:0];
          cmd_o.first = pos_q == '0;
          if (is_pred) begin
            cmd_o.op = DP_PRED;
            cmd_o.ch = pos_q[0];
          end else if (is_field) begin
            cmd_o.op      = DP_FIELD;
            cmd_o.field   = stereo_q ? q[3:2] : q[2:1];
            cmd_o.ch      = stereo_q & q[1];
            cmd_o.hi_half = q[0];
            if (last_hdr) begin
              emit_d  = 2'd0;
              state_d = S_EMIT;
            end
          end else begin
            cmd_o.op      = DP_MUL_C1;
            cmd_o.capture = 1'b1;
            cmd_o.ch      = 1'b0;
            cmd_o.code_lo = 1'b0;
            code_d        = 1'b0;
            state_d       = S_MUL2;
          end
        end
      end
      S_MUL1: begin
        cmd_o.op = DP_MUL_C1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = DP_MUL_C2;
        state_d  = S_MUL3;
      end
      S_MUL3: begin
        cmd_o.op = DP_MUL_STEP;
        state_d  = S_MUL4;
      end
      S_MUL4: begin
        cmd_o.op = DP_MUL_ADAPT;
        state_d  = S_WRITE;
      end
      S_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.op   = DP_WRITE;
          cmd_o.last = code_q;
          if (code_q) begin
            state_d = S_IDLE;
          end else begin
            code_d  = 1'b1;
            state_d = S_MUL1;
          end
        end
      end
      S_EMIT: begin
        cmd_o.ch         = stereo_q & emit_q[0];
        cmd_o.emit_newer = stereo_q ? emit_q[1] : emit_q[0];
        cmd_o.last       = emit_last;
        if (status_i.out_free) begin
          cmd_o.op = DP_EMIT;
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            emit_d = emit_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= '0;
      code_q   <= 1'b0;
      emit_q   <= '0;
      stereo_q <= 1'b0;
      bbytes_q <= CfgW'(256);
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      code_q  <= code_d;
      emit_q  <= emit_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStereo:     stereo_q <= cfg_wdata_i[0];
          CfgBlockBytes: bbytes_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: design/ms_adpcm_block_decoder_unit.sv
// ms_adpcm_block_decoder_unit: top level of the ms adpcm block decoder
// depends on msadpcm_pkg, msadpcm_if, msadpcm_ctrl and msadpcm_dp
//
// bytes of a block arrive on in_req (data_byte, block_end), one per request.
// the header (7 bytes mono, 14 stereo) sets predictor coefficients, step size
// and two history samples per channel; its last byte releases the history
// samples, older first, as 2 (mono) or 4 (stereo) requests on out_req.
// each later byte carries two 4-bit codes, high nibble first, and gives two
// decoded samples; last_of_item marks the final request caused by a byte.
// a header byte other than the last leaves the input ready; the last header
// byte holds it until each history sample is loaded for output, and a code
// byte holds it while the one shared multiplier does four products per code.
// the output register lets the next byte be taken while the final result of a
// byte still waits; a stalled receiver holds the sequencer at the next result.
// the user must write stereo and block_bytes on the cfg port only while the
// block is idle; the block itself does not enforce this. reset clears the
// channel state (step size 16), the position to block start and the
// configuration to mono with 256-byte blocks.

module ms_adpcm_block_decoder_unit import msadpcm_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = MaxBlockBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  msadpcm_in_if.sink         in_req,
  msadpcm_out_if.source      out_req
);

  dp_cmd_t    cmd;
  dp_status_t status;

  msadpcm_ctrl #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_req.valid),
    .in_block_end_i (in_req.block_end),
    .in_ready_o     (in_req.ready),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  msadpcm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .data_byte_i      (in_req.data_byte),
    .out_valid_o      (out_req.valid),
    .out_ready_i      (out_req.ready),
    .sample_value_o   (out_req.sample_value),
    .sample_channel_o (out_req.sample_channel),
    .last_of_item_o   (out_req.last_of_item),
    .bad_predictor_o  (out_req.bad_predictor)
  );

`ifndef ASSERT_OFF
  a_write_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_WRITE) |-> status.out_free)
    else $error("decode result loaded into a busy output register");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_EMIT) |-> status.out_free)
    else $error("history sample loaded into a busy output register");

  a_accept_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req.valid && in_req.ready) |->
      (cmd.op == DP_PRED || cmd.op == DP_FIELD || cmd.op == DP_MUL_C1))
    else $error("accepted byte without a header or decode command");

  a_mac_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_MUL_C2) |-> ($past(cmd.op) == DP_MUL_C1))
    else $error("second predictor product out of sequence");
`endif

endmodule

FILE: verif/ms_adpcm_block_decoder_unit_test.sv
// self-checking testbench of ms_adpcm_block_decoder_unit: a table of directed bytes, then
// random mono and stereo blocks, all checked against an in-bench decoder model
// depends on msadpcm_pkg, msadpcm_in_if, msadpcm_out_if and the decoder rtl
`timescale 1ns / 100ps

module ms_adpcm_block_decoder_unit_test import msadpcm_pkg::*; ;

  localparam int RunLimit = 200000;
  localparam int HoldOff  = 60;

  typedef struct packed {
    logic signed [15:0] value;
    logic               ch;
    logic               last;
    logic               bad;
  } pcm_t;

  typedef struct packed {
    logic [7:0]         data_v;
    logic               end_v;
    logic               typed;
    logic signed [15:0] want;
    logic               want_bad;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;

  msadpcm_in_if  in_req ();
  msadpcm_out_if out_req ();

  ms_adpcm_block_decoder_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_req      (in_req),
    .out_req     (out_req)
  );

  // decoder model state
  pcm_t       samples_due [$];
  int         k_one [2];
  int         k_two [2];
  int         step_sz [2];
  int         h_new [2];
  int         h_old [2];
  bit         stereo_m;
  int         blk_lim;
  int         pos;
  logic [7:0] lo_hold;
  bit         hdr_bad;

  // stimulus and bookkeeping
  row_t               script [21];
  int                 gpos;
  int                 glen;
  int                 faults;
  int                 bytes_taken;
  int                 samples_checked;
  int                 cycles;
  bit                 quiet;
  bit                 hold_ask;
  bit                 held;
  logic               in_typed;
  logic               in_want_bad;
  logic signed [15:0] in_want;
  pcm_t               got;
  pcm_t               due;

  function automatic int coef_lead(input logic [7:0] idx);
    case (idx)
      8'd1:    return 512;
      8'd2:    return 0;
      8'd3:    return 192;
      8'd4:    return 240;
      8'd5:    return 460;
      8'd6:    return 392;
      default: return 256;
    endcase
  endfunction

  function automatic int coef_trail(input logic [7:0] idx);
    case (idx)
      8'd1:    return -256;
      8'd3:    return 64;
      8'd5:    return -208;
      8'd6:    return -232;
      default: return 0;
    endcase
  endfunction

  function automatic int adapt_gain(input logic [3:0] u);
    case (u)
      4'd4, 4'd12: return 307;
      4'd5, 4'd11: return 409;
      4'd6, 4'd10: return 512;
      4'd7, 4'd9:  return 614;
      4'd8:        return 768;
      default:     return 230;
    endcase
  endfunction

  function automatic pcm_t make_pcm(input int v, input int c);
    pcm_t t;
    t.value = v[15:0];
    t.ch    = c[0];
    t.last  = 1'b0;
    t.bad   = hdr_bad;
    return t;
  endfunction

  function automatic int decode_nibble(input int c, input logic [3:0] u);
    int s;
    int pred;
    int r;
    int d;
    s    = u[3] ? int'(u) - 16 : int'(u);
    pred = h_new[c] * k_one[c] + h_old[c] * k_two[c];
    r    = pred / 256 + s * step_sz[c];
    if (r < -32768) r = -32768;
    if (r > 32767) r = 32767;
    d = (adapt_gain(u) * step_sz[c]) / 256;
    if (d < 16) d = 16;
    if (d > 32767) d = 32767;
    step_sz[c] = d;
    h_old[c]   = h_new[c];
    h_new[c]   = r;
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] raw, input logic fin, input logic typed,
                              input logic signed [15:0] want, input logic want_bad);
    int         chans;
    int         p;
    int         q;
    int         fld;
    int         c;
    int         v;
    logic [7:0] b;
    pcm_t       fresh [$];
    b     = raw;
    chans = stereo_m ? 2 : 1;
    p     = pos;
    if (p < chans) begin
      if (p == 0) hdr_bad = 1'b0;
      if (b > 8'd6) begin
        hdr_bad = 1'b1;
        b = 8'd0;
      end
      k_one[p] = coef_lead(b);
      k_two[p] = coef_trail(b);
    end else if (p < 7 * chans) begin
      q   = p - chans;
      fld = q / (2 * chans);
      c   = (q / 2) % chans;
      if (q % 2 == 0) begin
        lo_hold = b;
      end else begin
        v = int'($signed({b, lo_hold}));
        case (fld)
          0:       step_sz[c] = v;
          1:       h_new[c] = v;
          default: h_old[c] = v;
        endcase
      end
      if (p == 7 * chans - 1) begin
        for (c = 0; c < chans; c++) fresh = {fresh, make_pcm(h_old[c], c)};
        for (c = 0; c < chans; c++) fresh = {fresh, make_pcm(h_new[c], c)};
      end
    end else if (chans == 2) begin
      fresh = {fresh, make_pcm(decode_nibble(0, b[7:4]), 0)};
      fresh = {fresh, make_pcm(decode_nibble(1, b[3:0]), 1)};
    end else begin
      fresh = {fresh, make_pcm(decode_nibble(0, b[7:4]), 0)};
      fresh = {fresh, make_pcm(decode_nibble(0, b[3:0]), 0)};
    end
    if (fresh.size() > 0) begin
      fresh[fresh.size() - 1].last = 1'b1;
      if (typed) begin
        fresh[0].value = want;
        fresh[0].bad   = want_bad;
      end
      samples_due = {samples_due, fresh};
    end
    pos = (fin || p + 1 >= blk_lim) ? 0 : (p + 1) % 4096;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RunLimit) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles, samples_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // result checking and prediction on each accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_req.valid && out_req.ready) begin
        got = {out_req.sample_value, out_req.sample_channel, out_req.last_of_item,
               out_req.bad_predictor};
        if (samples_due.size() == 0) begin
          faults++;
          if (faults <= 10) $display("unexpected sample %0d on channel %0d", got.value, got.ch);
        end else begin
          due = samples_due.pop_front();
          samples_checked++;
          if (got !== due) begin
            faults++;
            if (faults <= 10)
              $display("sample %0d: value %0d/%0d ch %0d/%0d last %0d/%0d bad %0d/%0d (exp/act)",
                       samples_checked, due.value, got.value, due.ch, got.ch, due.last,
                       got.last, due.bad, got.bad);
          end
        end
      end
      if (in_req.valid && in_req.ready) begin
        bytes_taken++;
        predict_byte(in_req.data_byte, in_req.block_end, in_typed, in_want, in_want_bad);
      end
    end
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_req.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ask && !held) begin
        held = 1'b1;
        stall_left = HoldOff;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_req.ready <= 1'b0;
        stall_left--;
      end else begin
        out_req.ready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic [7:0] b, input logic e, input logic typed,
                       input logic signed [15:0] want, input logic want_bad);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_req.valid     <= 1'b1;
    in_req.data_byte <= b;
    in_req.block_end <= e;
    in_typed         <= typed;
    in_want          <= want;
    in_want_bad      <= want_bad;
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[CfgW-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgStereo) stereo_m = val[0];
    else if (val[12:0] < 16) blk_lim = 16;
    else if (val[12:0] > MaxBlockBytes) blk_lim = MaxBlockBytes;
    else blk_lim = int'(val[12:0]);
  endtask

  // let every expected sample arrive, then give trailing header bytes time to finish
  task automatic settle();
    @(posedge clk_i);
    while (samples_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic run_phase(input int mode, input int blen, input int count, input bit hush,
                           input bit squeeze);
    int         k;
    int         chans;
    int         hdr;
    int         q;
    logic [7:0] b;
    logic       e;
    settle();
    write_reg(CfgStereo, mode);
    write_reg(CfgBlockBytes, blen);
    quiet = hush;
    for (k = 0; k < count; k++) begin
      if (squeeze && k == 4) hold_ask = 1'b1;
      chans = stereo_m ? 2 : 1;
      hdr   = 7 * chans;
      if (gpos == 0) begin
        case ($urandom_range(0, 9))
          0:       glen = $urandom_range(1, hdr);
          1, 2:    glen = blk_lim;
          default: glen = hdr + $urandom_range(1, 10);
        endcase
        if (glen > blk_lim) glen = blk_lim;
      end
      if ($urandom_range(0, 9) == 0) begin
        b = 8'($urandom_range(0, 255));
        e = ($urandom_range(0, 7) == 0);
      end else begin
        e = (gpos + 1 >= glen);
        q = gpos - chans;
        if (gpos < chans)
          b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, 255))
                                          : 8'($urandom_range(0, 6));
        else if (gpos < hdr && q < 2 * chans && q % 2 == 1)
          b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 3));
        else
          b = 8'($urandom_range(0, 255));
      end
      gpos = (e || gpos + 1 >= blk_lim) ? 0 : (gpos + 1) % 4096;
      offer(b, e, 1'b0, 16'sh0000, 1'b0);
    end
    in_req.valid <= 1'b0;
  endtask

  initial begin
    int i;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CfgStereo;
    cfg_wdata        <= '0;
    in_req.valid     <= 1'b0;
    in_req.data_byte <= 8'h00;
    in_req.block_end <= 1'b0;
    in_typed         <= 1'b0;
    in_want          <= 16'sh0000;
    in_want_bad      <= 1'b0;
    for (i = 0; i < 2; i++) begin
      k_one[i]   = 0;
      k_two[i]   = 0;
      step_sz[i] = 16;
      h_new[i]   = 0;
      h_old[i]   = 0;
    end
    stereo_m = 1'b0;
    blk_lim  = 256;
    pos      = 0;
    lo_hold  = 8'h00;
    hdr_bad  = 1'b0;
    gpos     = 0;
    glen     = 0;
    quiet    = 1'b0;
    hold_ask = 1'b0;
    held     = 1'b0;

    // mono blocks after reset: bad predictor with negative step, a cut header, clamping
    script = '{
      '{8'h07, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h00, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h80, 1'b0, 1'b1, 16'sh8000, 1'b1},
      '{8'h7F, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h80, 1'b1, 1'b0, 16'sh0000, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h34, 1'b1, 1'b0, 16'sh0000, 1'b0},
      '{8'h01, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h00, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h80, 1'b0, 1'b1, 16'sh8000, 1'b0},
      '{8'h07, 1'b0, 1'b1, 16'sh7FFF, 1'b0},
      '{8'h88, 1'b0, 1'b0, 16'sh0000, 1'b0},
      '{8'h5A, 1'b1, 1'b0, 16'sh0000, 1'b0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < 21; i++)
      offer(script[i].data_v, script[i].end_v, script[i].typed, script[i].want,
            script[i].want_bad);
    in_req.valid <= 1'b0;

    run_phase(0, 16, 15, 1'b0, 1'b0);
    run_phase(1, 16, 20, 1'b0, 1'b1);
    run_phase(0, 8191, 15, 1'b0, 1'b0);
    run_phase(1, MaxBlockBytes, 15, 1'b0, 1'b0);
    run_phase(0, 0, 12, 1'b0, 1'b0);
    run_phase(1, $urandom_range(17, 64), 12, 1'b1, 1'b0);

    settle();
    if (samples_due.size() != 0) begin
      $display("%0d expected samples never arrived", samples_due.size());
      faults += samples_due.size();
    end
    $display("%0d bytes decoded into %0d checked samples, mono and stereo, blocks of 16 to %0d",
             bytes_taken, samples_checked, MaxBlockBytes);
    $display("bytes, with bad predictors, cut headers and a %0d-cycle output hold-off", HoldOff);
    if (faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", faults);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/msadpcm_pkg.sv
design/msadpcm_if.sv
design/msadpcm_dp.sv
design/msadpcm_ctrl.sv
design/ms_adpcm_block_decoder_unit.sv
verif/ms_adpcm_block_decoder_unit_test.sv
